[hw/rtl/stfs_pkg.sv]
`default_nettype none

package stfs_pkg;

  // Port field widths
  localparam int CMD_W  = 3;
  localparam int SLOT_W = 10;
  localparam int WORD_W = 32;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 10;

  // Lowest slot that is ever handed out
  localparam int FIRST_SLOT = 1;

  // Command codes (code 7 is unused)
  typedef enum logic [CMD_W-1:0] {
    CMD_ADD     = 3'd0,
    CMD_REPLACE = 3'd1,
    CMD_DELETE  = 3'd2,
    CMD_GET     = 3'd3,
    CMD_FIRST   = 3'd4,
    CMD_NEXT    = 3'd5,
    CMD_CLEAR   = 3'd6
  } cmd_e;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD  = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

endpackage

`default_nettype wire

[hw/rtl/stfs_ram.sv]
`default_nettype none

module stfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read; data follows the address in the next cycle
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[hw/rtl/slot_table_with_free_stack.sv]
// Add from the top, a full table, slot 0, first on an empty table and the unused code
// are answered straight from idle; add from the free stack, replace, delete, get and
// an empty slot first pass through a RAM read state. First scans from slot 1 up to
// the high mark; next checks its slot, then scans on. Clear sweeps the occupied bits.
// After reset the same sweep runs with busy high and no result.
// One item at a time; done_o pulses for one cycle and the receiver cannot stall.
`default_nettype none

module slot_table_with_free_stack #(
  parameter int SLOTS     = 1024,
  parameter int DATA_BITS = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [stfs_pkg::CMD_W-1:0]  command_i,
  input  wire logic [stfs_pkg::SLOT_W-1:0] slot_i,
  input  wire logic [stfs_pkg::WORD_W-1:0] data_i,
  output logic                             done_o,
  output logic [stfs_pkg::STAT_W-1:0]      status_o,
  output logic [stfs_pkg::SLOT_W-1:0]      result_slot_o,
  output logic [stfs_pkg::WORD_W-1:0]      result_data_o,
  output logic [stfs_pkg::CNT_W-1:0]       entry_count_o,
  output logic [stfs_pkg::CNT_W-1:0]       high_mark_o,
  output logic [stfs_pkg::CNT_W-1:0]       free_count_o
);

  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int KW = (DATA_BITS < stfs_pkg::WORD_W) ? DATA_BITS : stfs_pkg::WORD_W;
  localparam int EW = KW + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_POP  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_CLR  = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic          pend_q, pend_d;
  logic          rep_q, rep_d;
  logic [CW-1:0] free_q, free_d;
  logic [SW-1:0] high_q, high_d;
  logic [CW-1:0] tot_q, tot_d;
  logic          done_q, done_d;

  logic [stfs_pkg::CMD_W-1:0]  cmd_q, cmd_d;
  logic [SW-1:0]               slot_q, slot_d;
  logic [KW-1:0]               data_q, data_d;
  logic [SW-1:0]               chk_q, chk_d;
  logic [stfs_pkg::STAT_W-1:0] status_q, status_d;
  logic [SW-1:0]               rslot_q, rslot_d;
  logic [KW-1:0]               rdata_q, rdata_d;

  // Entry RAM: {occupied, data}
  logic          ent_we;
  logic [SW-1:0] ent_waddr, ent_raddr;
  logic [EW-1:0] ent_wdata, ent_rdata;

  // Free stack RAM
  logic          fs_we;
  logic [SW-1:0] fs_waddr, fs_raddr;
  logic [SW-1:0] fs_wdata, fs_rdata;

  logic          slot_ok;
  logic [SW-1:0] slot_idx;
  logic [SW-1:0] top_slot;

  stfs_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (ent_we),
    .waddr_i(ent_waddr),
    .wdata_i(ent_wdata),
    .raddr_i(ent_raddr),
    .rdata_o(ent_rdata)
  );

  stfs_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_free_ram (
    .clk_i  (clk_i),
    .we_i   (fs_we),
    .waddr_i(fs_waddr),
    .wdata_i(fs_wdata),
    .raddr_i(fs_raddr),
    .rdata_o(fs_rdata)
  );

  // Slot range check on the incoming item
  assign slot_ok  = (32'(slot_i) >= stfs_pkg::FIRST_SLOT) && (32'(slot_i) < SLOTS);
  assign slot_idx = SW'(slot_i);
  assign top_slot = high_q + SW'(1);

  // Sequencer: read, check, write back
  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    pend_d    = pend_q;
    rep_d     = rep_q;
    free_d    = free_q;
    high_d    = high_q;
    tot_d     = tot_q;
    done_d    = 1'b0;
    cmd_d     = cmd_q;
    slot_d    = slot_q;
    data_d    = data_q;
    chk_d     = chk_q;
    status_d  = stfs_pkg::ST_BAD;
    rslot_d   = '0;
    rdata_d   = '0;
    ent_we    = 1'b0;
    ent_waddr = '0;
    ent_wdata = '0;
    ent_raddr = '0;
    fs_we     = 1'b0;
    fs_waddr  = '0;
    fs_wdata  = '0;
    fs_raddr  = '0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_d  = command_i;
          slot_d = slot_idx;
          data_d = data_i[KW-1:0];
          case (command_i)
            stfs_pkg::CMD_ADD: begin
              if (free_q != '0) begin
                fs_raddr = SW'(free_q - CW'(1));
                state_d  = S_POP;
              end else if (32'(high_q) >= SLOTS - 1) begin
                done_d   = 1'b1;
                status_d = stfs_pkg::ST_FULL;
              end else begin
                // Grow above the high mark
                ent_we    = 1'b1;
                ent_waddr = top_slot;
                ent_wdata = {1'b1, data_i[KW-1:0]};
                high_d    = top_slot;
                tot_d     = tot_q + CW'(1);
                done_d    = 1'b1;
                status_d  = stfs_pkg::ST_OK;
                rslot_d   = top_slot;
              end
            end
            stfs_pkg::CMD_REPLACE, stfs_pkg::CMD_DELETE,
            stfs_pkg::CMD_GET, stfs_pkg::CMD_NEXT: begin
              if (slot_ok) begin
                ent_raddr = slot_idx;
                state_d   = S_CHK;
              end else begin
                done_d = 1'b1;
              end
            end
            stfs_pkg::CMD_FIRST: begin
              if (tot_q != '0) begin
                ptr_d   = CW'(stfs_pkg::FIRST_SLOT);
                pend_d  = 1'b0;
                state_d = S_SCAN;
              end else begin
                done_d = 1'b1;
              end
            end
            stfs_pkg::CMD_CLEAR: begin
              ptr_d   = '0;
              rep_d   = 1'b1;
              state_d = S_CLR;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      S_POP: begin
        // Reuse the slot on top of the free stack
        ent_we    = 1'b1;
        ent_waddr = fs_rdata;
        ent_wdata = {1'b1, data_q};
        free_d    = free_q - CW'(1);
        tot_d     = tot_q + CW'(1);
        done_d    = 1'b1;
        status_d  = stfs_pkg::ST_OK;
        rslot_d   = fs_rdata;
        state_d   = S_IDLE;
      end

      S_CHK: begin
        state_d = S_IDLE;
        if (!ent_rdata[KW]) begin
          done_d = 1'b1;
        end else begin
          case (cmd_q)
            stfs_pkg::CMD_REPLACE: begin
              ent_we    = 1'b1;
              ent_waddr = slot_q;
              ent_wdata = {1'b1, data_q};
              done_d    = 1'b1;
              status_d  = stfs_pkg::ST_OK;
            end
            stfs_pkg::CMD_DELETE: begin
              ent_we    = 1'b1;
              ent_waddr = slot_q;
              ent_wdata = {1'b0, ent_rdata[KW-1:0]};
              tot_d     = tot_q - CW'(1);
              if (slot_q == high_q) begin
                high_d = high_q - SW'(1);
              end else if (32'(free_q) < SLOTS) begin
                fs_we    = 1'b1;
                fs_waddr = SW'(free_q);
                fs_wdata = slot_q;
                free_d   = free_q + CW'(1);
              end
              done_d   = 1'b1;
              status_d = stfs_pkg::ST_OK;
            end
            stfs_pkg::CMD_GET: begin
              done_d   = 1'b1;
              status_d = stfs_pkg::ST_OK;
              rdata_d  = ent_rdata[KW-1:0];
            end
            stfs_pkg::CMD_NEXT: begin
              ptr_d   = CW'(slot_q) + CW'(1);
              pend_d  = 1'b0;
              state_d = S_SCAN;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      S_SCAN: begin
        // One read issued per cycle; the previous read is checked
        if (pend_q && ent_rdata[KW]) begin
          done_d   = 1'b1;
          status_d = stfs_pkg::ST_OK;
          rslot_d  = chk_q;
          rdata_d  = ent_rdata[KW-1:0];
          pend_d   = 1'b0;
          state_d  = S_IDLE;
        end else if (ptr_q <= CW'(high_q)) begin
          ent_raddr = SW'(ptr_q);
          chk_d     = SW'(ptr_q);
          pend_d    = 1'b1;
          ptr_d     = ptr_q + CW'(1);
        end else begin
          done_d  = 1'b1;
          pend_d  = 1'b0;
          state_d = S_IDLE;
        end
      end

      S_CLR: begin
        // Sweep occupied bits, one entry per cycle
        ent_we    = 1'b1;
        ent_waddr = SW'(ptr_q);
        ent_wdata = '0;
        if (ptr_q == CW'(SLOTS - 1)) begin
          tot_d   = '0;
          high_d  = '0;
          free_d  = '0;
          done_d  = rep_q;
          status_d = stfs_pkg::ST_OK;
          rep_d   = 1'b0;
          state_d = S_IDLE;
        end else begin
          ptr_d = ptr_q + CW'(1);
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers; reset starts the clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      ptr_q   <= '0;
      pend_q  <= 1'b0;
      rep_q   <= 1'b0;
      free_q  <= '0;
      high_q  <= '0;
      tot_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      pend_q  <= pend_d;
      rep_q   <= rep_d;
      free_q  <= free_d;
      high_q  <= high_d;
      tot_q   <= tot_d;
      done_q  <= done_d;
    end
  end

  // Item and result payload
  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    slot_q   <= slot_d;
    data_q   <= data_d;
    chk_q    <= chk_d;
    status_q <= status_d;
    rslot_q  <= rslot_d;
    rdata_q  <= rdata_d;
  end

  assign busy          = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign result_slot_o = stfs_pkg::SLOT_W'(rslot_q);
  assign result_data_o = stfs_pkg::WORD_W'(rdata_q);
  assign entry_count_o = stfs_pkg::CNT_W'(tot_q);
  assign high_mark_o   = stfs_pkg::CNT_W'(high_q);
  assign free_count_o  = stfs_pkg::CNT_W'(free_q);

`ifndef NO_ASSERTIONS
  // Free and occupied slots are distinct and all lie at or below the high mark
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(free_q) + 32'(tot_q) <= 32'(high_q)))
    else $error("free plus occupied count exceeds high mark");

  // A clear holds the block busy for its sweep
  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && command_i == stfs_pkg::CMD_CLEAR) |=> busy)
    else $error("clear did not start its sweep");

  // Full is only reported with an empty free stack
  a_full_stack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == stfs_pkg::ST_FULL) |-> (free_count_o == '0))
    else $error("full reported with slots on the free stack");
`endif

endmodule

`default_nettype wire

[dv/testbench.sv]
`default_nettype none

module testbench;
  import stfs_pkg::*;

  localparam int SLOTS        = 1024;
  localparam int DATA_BITS    = 32;
  localparam int IDLE_LIMIT   = 20000;
  localparam int RANDOM_ITEMS = 300;
  localparam int SHOW_LIMIT   = 10;

  // Code 7 has no operation behind it
  localparam logic [CMD_W-1:0]  CMD_UNUSED = 3'd7;
  localparam logic [WORD_W-1:0] WORD_KEEP  = {WORD_W{1'b1}} >> (WORD_W - DATA_BITS);

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot;
    logic [WORD_W-1:0] word;
    logic [CNT_W-1:0]  count;
    logic [CNT_W-1:0]  high;
    logic [CNT_W-1:0]  free;
  } table_reply_t;

  // DUT signals
  logic              clk_i     = 1'b0;
  logic              rst_ni    = 1'b0;
  logic              start     = 1'b0;
  logic [CMD_W-1:0]  command_i = CMD_ADD;
  logic [SLOT_W-1:0] slot_i    = '0;
  logic [WORD_W-1:0] data_i    = '0;
  logic              busy;
  logic              done_o;
  logic [STAT_W-1:0] status_o;
  logic [SLOT_W-1:0] result_slot_o;
  logic [WORD_W-1:0] result_data_o;
  logic [CNT_W-1:0]  entry_count_o;
  logic [CNT_W-1:0]  high_mark_o;
  logic [CNT_W-1:0]  free_count_o;

  // Shadow copy of the table
  logic              slot_used [SLOTS] = '{default: 1'b0};
  logic [WORD_W-1:0] slot_word [SLOTS];
  logic [SLOT_W-1:0] free_lifo [SLOTS];
  int                lifo_depth = 0;
  int                top_mark   = 0;
  int                used_total = 0;

  table_reply_t pending_replies [$];

  int sent_count    = 0;
  int checked_count = 0;
  int fault_count   = 0;
  int full_count    = 0;
  int peak_mark     = 0;
  int burst_left    = 0;
  int last_found    = 0;
  int idle_cycles   = 0;

  always #10 clk_i = ~clk_i;

  slot_table_with_free_stack #(
    .SLOTS     (SLOTS),
    .DATA_BITS (DATA_BITS)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .command_i     (command_i),
    .slot_i        (slot_i),
    .data_i        (data_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .result_slot_o (result_slot_o),
    .result_data_o (result_data_o),
    .entry_count_o (entry_count_o),
    .high_mark_o   (high_mark_o),
    .free_count_o  (free_count_o)
  );

  // Lowest occupied slot from a given index up to the high mark, 0 if none
  function automatic int scan_used(int from);
    for (int i = from; i < SLOTS && i <= top_mark; i++) begin
      if (slot_used[i]) return i;
    end
    return 0;
  endfunction

  // Applies one command to the shadow table and returns the reply it should give
  function automatic table_reply_t predict_table_reply(logic [CMD_W-1:0] cmd,
                                                       logic [SLOT_W-1:0] slot,
                                                       logic [WORD_W-1:0] word);
    table_reply_t reply;
    logic         live;
    int           where;
    reply        = '0;
    reply.status = ST_BAD;
    word         = word & WORD_KEEP;
    live         = (int'(slot) >= FIRST_SLOT) && (int'(slot) < SLOTS) && slot_used[slot];
    where        = 0;
    case (cmd)
      CMD_ADD: begin
        // free stack first, then the slot above the high mark
        if (lifo_depth > 0) begin
          lifo_depth--;
          where = free_lifo[lifo_depth];
        end else if (top_mark < SLOTS - 1) begin
          top_mark++;
          where = top_mark;
        end
        if (where == 0) begin
          reply.status = ST_FULL;
        end else begin
          slot_word[where] = word;
          slot_used[where] = 1'b1;
          used_total++;
          reply.status = ST_OK;
          reply.slot   = SLOT_W'(where);
        end
      end
      CMD_REPLACE: begin
        if (live) begin
          slot_word[slot] = word;
          reply.status    = ST_OK;
        end
      end
      CMD_DELETE: begin
        if (live) begin
          slot_used[slot] = 1'b0;
          used_total--;
          // deleting the top slot trims the mark by one, others go on the stack
          if (int'(slot) == top_mark) begin
            top_mark--;
          end else if (lifo_depth < SLOTS) begin
            free_lifo[lifo_depth] = slot;
            lifo_depth++;
          end
          reply.status = ST_OK;
        end
      end
      CMD_GET: begin
        if (live) begin
          reply.word   = slot_word[slot];
          reply.status = ST_OK;
        end
      end
      CMD_FIRST, CMD_NEXT: begin
        if (cmd == CMD_FIRST) where = (used_total != 0) ? scan_used(FIRST_SLOT) : 0;
        else where = live ? scan_used(int'(slot) + 1) : 0;
        if (where != 0) begin
          reply.status = ST_OK;
          reply.slot   = SLOT_W'(where);
          reply.word   = slot_word[where];
        end
      end
      CMD_CLEAR: begin
        slot_used    = '{default: 1'b0};
        lifo_depth   = 0;
        top_mark     = 0;
        used_total   = 0;
        reply.status = ST_OK;
      end
      default: ;
    endcase
    reply.count = CNT_W'(used_total);
    reply.high  = CNT_W'(top_mark);
    reply.free  = CNT_W'(lifo_depth);
    return reply;
  endfunction

  task automatic report_fault(input string what);
    fault_count++;
    if (fault_count <= SHOW_LIMIT) $display("%0t: %s", $time, what);
  endtask

  // Sends one item; the sender runs in bursts with random gaps in between
  task automatic issue_command(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
                               input logic [WORD_W-1:0] word);
    table_reply_t reply;
    if (burst_left == 0) begin
      start <= 1'b0;
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(10, 30)) @(posedge clk_i);
      else repeat ($urandom_range(1, 4)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    command_i <= cmd;
    slot_i    <= slot;
    data_i    <= word;
    start     <= 1'b1;
    do @(posedge clk_i); while (busy !== 1'b0);
    reply = predict_table_reply(cmd, slot, word);
    pending_replies.push_back(reply);
    sent_count++;
    burst_left--;
    if (top_mark > peak_mark) peak_mark = top_mark;
    if (reply.status == ST_FULL) full_count++;
    if (cmd == CMD_FIRST || cmd == CMD_NEXT) last_found = reply.slot;
  endtask

  // Mostly slots at or below the high mark, sometimes slot 0 or anywhere
  function automatic logic [SLOT_W-1:0] pick_slot();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 8) return SLOT_W'($urandom_range(1, (top_mark > 1) ? top_mark : 1));
    if (roll == 8) return '0;
    return SLOT_W'($urandom_range(0, SLOTS - 1));
  endfunction

  // Checks each reply against the oldest prediction
  always @(posedge clk_i) begin : reply_check
    table_reply_t want;
    table_reply_t got;
    if (rst_ni && done_o === 1'b1) begin
      got = '{status_o, result_slot_o, result_data_o, entry_count_o, high_mark_o, free_count_o};
      if (pending_replies.size() == 0) begin
        report_fault($sformatf("reply with nothing pending: %p", got));
      end else begin
        want = pending_replies.pop_front();
        checked_count++;
        if (got.status !== want.status || got.slot !== want.slot || got.word !== want.word ||
            got.count !== want.count || got.high !== want.high || got.free !== want.free) begin
          report_fault($sformatf("reply %0d mismatch: expected %p, got %p",
                                 checked_count, want, got));
        end
      end
    end
  end

  // Watchdog: ends the run after too many cycles without a handshake
  always @(posedge clk_i) begin
    if ((rst_ni && start && busy === 1'b0) || done_o === 1'b1) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles, %0d replies pending",
               IDLE_LIMIT, pending_replies.size());
      $display("testbench: errors");
      $finish;
    end
  end

  // Empty table: nothing found, invalid and empty slots, unused code
  task automatic test_empty_table();
    issue_command(CMD_FIRST, '0, $urandom);
    issue_command(CMD_GET, '0, $urandom);
    issue_command(CMD_NEXT, '0, $urandom);
    issue_command(CMD_DELETE, 10'h3FF, $urandom);
    issue_command(CMD_UNUSED, 10'h155, 32'hFFFF_FFFF);
  endtask

  // Adds from the top and from the free stack, replace, get, scans, trim
  task automatic test_table_ops();
    issue_command(CMD_ADD, 10'h2AA, 32'hFFFF_FFFF);
    issue_command(CMD_ADD, '0, 32'h0000_0000);
    issue_command(CMD_ADD, '0, $urandom);
    issue_command(CMD_ADD, '0, $urandom);
    issue_command(CMD_REPLACE, 10'd2, 32'hA5A5_5A5A);
    issue_command(CMD_GET, 10'd2, $urandom);
    issue_command(CMD_FIRST, '0, $urandom);
    issue_command(CMD_NEXT, 10'd3, $urandom);
    issue_command(CMD_NEXT, 10'd4, $urandom);
    issue_command(CMD_DELETE, 10'd2, $urandom);
    issue_command(CMD_DELETE, 10'd3, $urandom);
    issue_command(CMD_NEXT, 10'd1, $urandom);
    issue_command(CMD_REPLACE, 10'd3, $urandom);
    issue_command(CMD_ADD, '0, $urandom);
    issue_command(CMD_ADD, '0, $urandom);
    issue_command(CMD_DELETE, 10'd4, $urandom);
    issue_command(CMD_GET, 10'd4, $urandom);
    issue_command(CMD_REPLACE, '0, $urandom);
    issue_command(CMD_DELETE, 10'h3FF, $urandom);
    issue_command(CMD_CLEAR, 10'h3FF, 32'hFFFF_FFFF);
  endtask

  // Fills every slot, then runs into a full table at both ends
  task automatic test_table_full();
    repeat (SLOTS - 1) issue_command(CMD_ADD, '0, $urandom);
    issue_command(CMD_ADD, '0, $urandom);
    issue_command(CMD_DELETE, 10'd500, $urandom);
    issue_command(CMD_ADD, '0, $urandom);
    issue_command(CMD_ADD, '0, $urandom);
    issue_command(CMD_GET, 10'h3FF, $urandom);
    issue_command(CMD_NEXT, 10'h3FE, $urandom);
    issue_command(CMD_NEXT, 10'h3FF, $urandom);
    issue_command(CMD_DELETE, 10'h3FF, $urandom);
    issue_command(CMD_CLEAR, '0, $urandom);
  endtask

  // Random traffic; the share of adds shifts so the table fills and drains
  task automatic test_random_traffic();
    int               add_share;
    int               roll;
    logic [CMD_W-1:0]  cmd;
    logic [SLOT_W-1:0] slot;
    add_share = 350;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) add_share = $urandom_range(150, 650);
      slot = pick_slot();
      roll = $urandom_range(0, 999);
      if ($urandom_range(0, 999) < add_share) begin
        cmd = CMD_ADD;
      end else if (roll < 180) begin
        cmd = CMD_REPLACE;
      end else if (roll < 420) begin
        cmd = CMD_DELETE;
      end else if (roll < 600) begin
        cmd = CMD_GET;
      end else if (roll < 690) begin
        cmd = CMD_FIRST;
      end else if (roll < 880) begin
        // walk on from the last slot found most of the time
        cmd = CMD_NEXT;
        if (last_found != 0 && $urandom_range(0, 3) != 0) slot = SLOT_W'(last_found);
      end else if (roll < 890) begin
        cmd = CMD_CLEAR;
      end else if (roll < 920) begin
        cmd = CMD_UNUSED;
      end else begin
        cmd  = CMD_W'($urandom_range(0, 7));
        slot = SLOT_W'($urandom_range(0, SLOTS - 1));
      end
      issue_command(cmd, slot, $urandom);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_empty_table();
    test_table_ops();
    test_table_full();
    test_random_traffic();
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (SLOTS + 16) @(posedge clk_i);
    $display("run covered %0d items and %0d checked replies, peak high mark %0d",
             sent_count, checked_count, peak_mark);
    $display("full-table replies %0d, mismatches %0d", full_count, fault_count);
    if (fault_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
